// File: rtl/core/mddsd_pkg.sv
// Shared types and constants of the min differential dispersion swap descent block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mddsd_pkg;

   localparam int IDX_W      = 6;
   localparam int NUM_ELEM   = 64;
   localparam int NUM_CHOSEN = 32;
   localparam int CHS_W      = 5;
   localparam int DIST_W     = 16;
   localparam int GAIN_W     = 21;
   localparam int SGN_W      = 24;
   localparam int DADDR_W    = 2 * IDX_W;

   localparam logic [1:0] KIND_DIST = 2'd0;
   localparam logic [1:0] KIND_MARK = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;

   localparam logic [1:0] ST_LOCAL    = 2'd0;
   localparam logic [1:0] ST_LIMIT    = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_SCAN, OP_ERR_OUT,
      OP_G_RDE, OP_G_LATE, OP_G_RDX, OP_G_RDD, OP_G_ACC, OP_G_WR, OP_COST,
      OP_P_INIT, OP_P_RD, OP_P_LAT, OP_K_RD, OP_K_E, OP_K_G, OP_K_A,
      OP_P_EVAL, OP_P_CMP, OP_A_WR, OP_U_RD, OP_U_E, OP_U_B, OP_U_W, OP_U_GA,
      OP_E_RD, OP_E_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic               accept;
      logic [CHS_W-1:0]   ci;
      logic [IDX_W-1:0]   ui;
      logic [IDX_W-1:0]   si;
      logic               wr_ok;
      logic               first;
      logic               diff;
      logic               last;
      logic [1:0]         status;
      logic [DADDR_W-1:0] clr_addr;
   } dp_cmd_type;

   typedef struct packed {
      logic mark;
      logic found;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/mddsd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; used for every store of the block.
`default_nettype none

module mddsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/mddsd_dp.sv
// Datapath: distance, list and gain stores, swap evaluation arithmetic, result register.
// Depends on mddsd_pkg and mddsd_ram; driven by commands from mddsd_ctrl.
`default_nettype none

module mddsd_dp
   import mddsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_stat_type            stat,
   input  wire logic [1:0]        req_kind,
   input  wire logic [IDX_W-1:0]  req_first_index,
   input  wire logic [IDX_W-1:0]  req_second_index,
   input  wire logic [DIST_W-1:0] req_distance,
   input  wire logic              req_member_flag,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [IDX_W-1:0]       rsp_chosen_element,
   output logic [GAIN_W-1:0]      rsp_solution_cost,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);

   function automatic logic [DADDR_W-1:0] pair_addr(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
      return (a < b) ? {a, b} : {b, a};
   endfunction

   logic                   c_we, u_we, g_we, d_we;
   logic [CHS_W-1:0]       c_waddr;
   logic [IDX_W-1:0]       c_wdata, c_q, u_waddr, u_wdata, u_q, g_waddr;
   logic [GAIN_W-1:0]      g_wdata, g_q;
   logic [DADDR_W-1:0]     d_waddr, d_raddr;
   logic [DIST_W-1:0]      d_wdata, d_q;

   logic [NUM_ELEM-1:0]    mark_ff;
   logic                   rsp_valid_ff;
   logic                   load_out;

   logic [IDX_W-1:0]       e_ff, rem_ff, add_ff, brem_ff, badd_ff, bj_ff;
   logic [CHS_W-1:0]       bi_ff;
   logic [GAIN_W-1:0]      acc_ff, maxg_ff, ming_ff, cost_ff, addg_ff, ga_ff;
   logic [DIST_W-1:0]      dadd_ff;
   logic signed [GAIN_W+1:0] tmp_ff, emax_ff, emin_ff, gval;
   logic                   any_ff, found_ff;
   logic signed [SGN_W-1:0] delta_ff, best_ff, hi, lo, addg_s, emax_s, emin_s;

   mddsd_ram #(.WIDTH(IDX_W), .DEPTH(NUM_CHOSEN)) u_clist (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(cmd.ci), .rd_data(c_q));

   mddsd_ram #(.WIDTH(IDX_W), .DEPTH(NUM_ELEM)) u_ulist (
      .clock(clock), .wr_en(u_we), .wr_addr(u_waddr), .wr_data(u_wdata),
      .rd_addr(cmd.ui), .rd_data(u_q));

   mddsd_ram #(.WIDTH(GAIN_W), .DEPTH(NUM_ELEM)) u_gain (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
      .rd_addr(c_q), .rd_data(g_q));

   mddsd_ram #(.WIDTH(DIST_W), .DEPTH(NUM_ELEM * NUM_ELEM)) u_dist (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_addr(d_raddr), .rd_data(d_q));

   always_comb begin
      c_we    = 1'b0;
      c_waddr = cmd.ci;
      c_wdata = cmd.si;
      u_we    = 1'b0;
      u_waddr = cmd.ui;
      u_wdata = cmd.si;
      if (cmd.op == OP_SCAN) begin
         c_we = mark_ff[cmd.si] & cmd.wr_ok;
         u_we = ~mark_ff[cmd.si];
      end else if (cmd.op == OP_A_WR) begin
         c_we    = 1'b1;
         c_waddr = bi_ff;
         c_wdata = badd_ff;
         u_we    = 1'b1;
         u_waddr = bj_ff;
         u_wdata = brem_ff;
      end
   end

   always_comb begin
      d_we    = 1'b0;
      d_waddr = pair_addr(req_first_index, req_second_index);
      d_wdata = req_distance;
      if (cmd.op == OP_CLEAR) begin
         d_we    = 1'b1;
         d_waddr = cmd.clr_addr;
         d_wdata = '0;
      end else if (cmd.accept && req_kind == KIND_DIST) begin
         d_we = 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.op)
         OP_K_E:  d_raddr = pair_addr(c_q, rem_ff);
         OP_K_G:  d_raddr = pair_addr(e_ff, add_ff);
         OP_U_E:  d_raddr = pair_addr(c_q, badd_ff);
         OP_U_B:  d_raddr = pair_addr(e_ff, brem_ff);
         default: d_raddr = pair_addr(e_ff, c_q);
      endcase
   end

   always_comb begin
      g_we    = 1'b0;
      g_waddr = e_ff;
      g_wdata = acc_ff;
      unique case (cmd.op)
         OP_G_WR: g_we = 1'b1;
         OP_U_W: begin
            g_we    = (e_ff != badd_ff);
            g_wdata = GAIN_W'(tmp_ff - signed'({7'd0, d_q}));
         end
         OP_U_GA: begin
            g_we    = 1'b1;
            g_waddr = badd_ff;
            g_wdata = ga_ff;
         end
         default: g_we = 1'b0;
      endcase
   end

   assign gval   = tmp_ff + signed'({7'd0, d_q});
   assign addg_s = signed'({3'd0, addg_ff});
   assign emax_s = {emax_ff[GAIN_W+1], emax_ff};
   assign emin_s = {emin_ff[GAIN_W+1], emin_ff};
   assign hi     = (addg_s > emax_s) ? addg_s : emax_s;
   assign lo     = (addg_s < emin_s) ? addg_s : emin_s;

   assign load_out = (!rsp_valid_ff || rsp_ready) &&
                     (cmd.op == OP_E_OUT || cmd.op == OP_ERR_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept && req_kind == KIND_MARK) begin
            mark_ff[req_first_index] <= req_member_flag;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_G_LATE: begin
            e_ff   <= c_q;
            acc_ff <= '0;
         end
         OP_G_ACC: begin
            if (cmd.diff) begin
               acc_ff <= acc_ff + GAIN_W'(d_q);
            end
         end
         OP_G_WR: begin
            if (cmd.first || acc_ff > maxg_ff) maxg_ff <= acc_ff;
            if (cmd.first || acc_ff < ming_ff) ming_ff <= acc_ff;
         end
         OP_COST: cost_ff <= maxg_ff - ming_ff;
         OP_P_INIT: begin
            best_ff  <= '0;
            found_ff <= 1'b0;
         end
         OP_P_LAT: begin
            rem_ff  <= c_q;
            add_ff  <= u_q;
            any_ff  <= 1'b0;
            addg_ff <= '0;
         end
         OP_K_E: e_ff <= c_q;
         OP_K_G: tmp_ff <= signed'({2'd0, g_q}) - signed'({7'd0, d_q});
         OP_K_A: begin
            if (e_ff != rem_ff) begin
               if (!any_ff || gval > emax_ff) emax_ff <= gval;
               if (!any_ff || gval < emin_ff) emin_ff <= gval;
               any_ff  <= 1'b1;
               addg_ff <= addg_ff + GAIN_W'(d_q);
            end
         end
         OP_P_EVAL: delta_ff <= hi - lo - signed'({3'd0, cost_ff});
         OP_P_CMP: begin
            if (delta_ff < best_ff) begin
               best_ff  <= delta_ff;
               bi_ff    <= cmd.ci;
               bj_ff    <= cmd.ui;
               brem_ff  <= rem_ff;
               badd_ff  <= add_ff;
               found_ff <= 1'b1;
            end
         end
         OP_A_WR: ga_ff <= '0;
         OP_U_E: e_ff <= c_q;
         OP_U_B: begin
            tmp_ff  <= signed'({2'd0, g_q}) + signed'({7'd0, d_q});
            dadd_ff <= d_q;
         end
         OP_U_W: begin
            if (e_ff != badd_ff) ga_ff <= ga_ff + GAIN_W'(dadd_ff);
         end
         OP_U_GA: cost_ff <= cost_ff + best_ff[GAIN_W-1:0];
         default: ;
      endcase
      if (load_out) begin
         if (cmd.op == OP_ERR_OUT) begin
            rsp_chosen_element <= '0;
            rsp_solution_cost  <= '0;
            rsp_status         <= ST_MISMATCH;
            rsp_last           <= 1'b1;
         end else begin
            rsp_chosen_element <= c_q;
            rsp_solution_cost  <= cost_ff;
            rsp_status         <= cmd.status;
            rsp_last           <= cmd.last;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign stat.mark     = mark_ff[cmd.si];
   assign stat.found    = found_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// File: rtl/core/mddsd_ctrl.sv
// Controller: sequences clearing, scan, gain setup, swap passes, update and emit.
// Depends on mddsd_pkg; drives mddsd_dp by command and reads its status.
`default_nettype none

module mddsd_ctrl
   import mddsd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_kind,
   input  wire logic [6:0]   element_count,
   input  wire logic [5:0]   chosen_count,
   input  wire logic [15:0]  max_passes,
   input  wire dp_stat_type  stat,
   output dp_cmd_type        cmd
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_CHECK, S_ERR,
      S_G_RDE, S_G_LATE, S_G_RDX, S_G_RDD, S_G_ACC, S_G_WR, S_COST,
      S_P_INIT, S_P_RD, S_P_LAT, S_K_RD, S_K_E, S_K_G, S_K_A,
      S_P_EVAL, S_P_CMP, S_P_END, S_A_WR, S_U_RD, S_U_E, S_U_B, S_U_W, S_U_GA,
      S_E_RD, S_E_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [6:0]         n_ff, n_in, nc_ff, nc_in, nu_ff, nu_in;
   logic [5:0]         m_ff, m_in, i_ff, i_in, j_ff, j_in;
   logic [CHS_W-1:0]   k_ff, k_in;
   logic [15:0]        pass_ff, pass_in;
   logic [1:0]         stat_ff, stat_in;
   logic [DADDR_W-1:0] clr_ff, clr_in;
   logic               i_last_m, j_last_m, k_last_m, i_last_n, j_last_u;

   assign i_last_m = (i_ff == m_ff - 6'd1);
   assign j_last_m = (j_ff == m_ff - 6'd1);
   assign k_last_m = ({1'b0, k_ff} == m_ff - 6'd1);
   assign i_last_n = ({1'b0, i_ff} == n_ff - 7'd1);
   assign j_last_u = ({1'b0, j_ff} == nu_ff - 7'd1);

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      nc_in    = nc_ff;
      nu_in    = nu_ff;
      pass_in  = pass_ff;
      stat_in  = stat_ff;
      clr_in   = clr_ff;
      req_ready = 1'b0;

      cmd.op       = OP_NONE;
      cmd.accept   = 1'b0;
      cmd.ci       = i_ff[CHS_W-1:0];
      cmd.ui       = j_ff;
      cmd.si       = i_ff;
      cmd.wr_ok    = 1'b0;
      cmd.first    = (i_ff == 6'd0);
      cmd.diff     = (j_ff != i_ff);
      cmd.last     = i_last_m;
      cmd.status   = stat_ff;
      cmd.clr_addr = clr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_kind == KIND_RUN) begin
               // saturate the instance size registers into the supported range
               priority if (element_count < 7'd3) n_in = 7'd3;
               else if (element_count > 7'(NUM_ELEM)) n_in = 7'(NUM_ELEM);
               else n_in = element_count;
               priority if (chosen_count < 6'd2) m_in = 6'd2;
               else if (chosen_count > 6'(NUM_CHOSEN)) m_in = 6'(NUM_CHOSEN);
               else m_in = chosen_count;
               i_in     = '0;
               nc_in    = '0;
               nu_in    = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op    = OP_SCAN;
            cmd.ci    = nc_ff[CHS_W-1:0];
            cmd.ui    = nu_ff[IDX_W-1:0];
            cmd.wr_ok = (nc_ff < 7'(NUM_CHOSEN));
            if (stat.mark) nc_in = nc_ff + 7'd1;
            else nu_in = nu_ff + 7'd1;
            i_in = i_ff + 6'd1;
            if (i_last_n) state_in = S_CHECK;
         end
         S_CHECK: begin
            i_in = '0;
            if (nc_ff != {1'b0, m_ff}) state_in = S_ERR;
            else state_in = S_G_RDE;
         end
         S_ERR: begin
            cmd.op = OP_ERR_OUT;
            if (stat.out_free) state_in = S_IDLE;
         end
         S_G_RDE: begin
            cmd.op   = OP_G_RDE;
            state_in = S_G_LATE;
         end
         S_G_LATE: begin
            cmd.op   = OP_G_LATE;
            j_in     = '0;
            state_in = S_G_RDX;
         end
         S_G_RDX: begin
            cmd.op   = OP_G_RDX;
            cmd.ci   = j_ff[CHS_W-1:0];
            state_in = S_G_RDD;
         end
         S_G_RDD: begin
            cmd.op   = OP_G_RDD;
            cmd.ci   = j_ff[CHS_W-1:0];
            state_in = S_G_ACC;
         end
         S_G_ACC: begin
            cmd.op = OP_G_ACC;
            cmd.ci = j_ff[CHS_W-1:0];
            j_in   = j_ff + 6'd1;
            if (j_last_m) state_in = S_G_WR;
            else state_in = S_G_RDX;
         end
         S_G_WR: begin
            cmd.op = OP_G_WR;
            i_in   = i_ff + 6'd1;
            if (i_last_m) state_in = S_COST;
            else state_in = S_G_RDE;
         end
         S_COST: begin
            cmd.op   = OP_COST;
            pass_in  = '0;
            state_in = S_P_INIT;
         end
         S_P_INIT: begin
            cmd.op = OP_P_INIT;
            i_in   = '0;
            j_in   = '0;
            if (nu_ff == 7'd0) begin
               stat_in  = ST_LOCAL;
               state_in = S_E_RD;
            end else begin
               state_in = S_P_RD;
            end
         end
         S_P_RD: begin
            cmd.op   = OP_P_RD;
            state_in = S_P_LAT;
         end
         S_P_LAT: begin
            cmd.op   = OP_P_LAT;
            k_in     = '0;
            state_in = S_K_RD;
         end
         S_K_RD: begin
            cmd.op   = OP_K_RD;
            cmd.ci   = k_ff;
            state_in = S_K_E;
         end
         S_K_E: begin
            cmd.op   = OP_K_E;
            cmd.ci   = k_ff;
            state_in = S_K_G;
         end
         S_K_G: begin
            cmd.op   = OP_K_G;
            cmd.ci   = k_ff;
            state_in = S_K_A;
         end
         S_K_A: begin
            cmd.op = OP_K_A;
            cmd.ci = k_ff;
            k_in   = k_ff + 1'b1;
            if (k_last_m) state_in = S_P_EVAL;
            else state_in = S_K_RD;
         end
         S_P_EVAL: begin
            cmd.op   = OP_P_EVAL;
            state_in = S_P_CMP;
         end
         S_P_CMP: begin
            cmd.op = OP_P_CMP;
            // advance the add index first, then the remove index
            if (j_last_u) begin
               j_in = '0;
               if (i_last_m) state_in = S_P_END;
               else begin
                  i_in     = i_ff + 6'd1;
                  state_in = S_P_RD;
               end
            end else begin
               j_in     = j_ff + 6'd1;
               state_in = S_P_RD;
            end
         end
         S_P_END: begin
            i_in = '0;
            if (!stat.found) begin
               stat_in  = ST_LOCAL;
               state_in = S_E_RD;
            end else begin
               state_in = S_A_WR;
            end
         end
         S_A_WR: begin
            cmd.op   = OP_A_WR;
            i_in     = '0;
            state_in = S_U_RD;
         end
         S_U_RD: begin
            cmd.op   = OP_U_RD;
            state_in = S_U_E;
         end
         S_U_E: begin
            cmd.op   = OP_U_E;
            state_in = S_U_B;
         end
         S_U_B: begin
            cmd.op   = OP_U_B;
            state_in = S_U_W;
         end
         S_U_W: begin
            cmd.op = OP_U_W;
            i_in   = i_ff + 6'd1;
            if (i_last_m) state_in = S_U_GA;
            else state_in = S_U_RD;
         end
         S_U_GA: begin
            cmd.op  = OP_U_GA;
            pass_in = pass_ff + 16'd1;
            i_in    = '0;
            if (pass_ff + 16'd1 >= max_passes) begin
               stat_in  = ST_LIMIT;
               state_in = S_E_RD;
            end else begin
               state_in = S_P_INIT;
            end
         end
         S_E_RD: begin
            cmd.op   = OP_E_RD;
            state_in = S_E_OUT;
         end
         S_E_OUT: begin
            cmd.op = OP_E_OUT;
            if (stat.out_free) begin
               if (i_last_m) state_in = S_IDLE;
               else begin
                  i_in     = i_ff + 6'd1;
                  state_in = S_E_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      n_ff    <= n_in;
      m_ff    <= m_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      nc_ff   <= nc_in;
      nu_ff   <= nu_in;
      pass_ff <= pass_in;
      stat_ff <= stat_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/min_diff_dispersion_swap_descent.sv
// Top level of the min differential dispersion swap descent block.
// Holds the configuration registers; instantiates mddsd_ctrl and mddsd_dp (mddsd_pkg).
//
// Usage: items enter on the req_ channel (valid/ready). A distance write or a
// membership mark is stored when it is taken; req_ready stays high for more items.
// A run item lists the chosen and unchosen elements, builds the gains, then
// runs swap passes. One pass walks every remove/add pair through the shared gain
// and distance read ports; the best swap found in the pass is then applied
// and the gains updated. The run then emits its m results on the rsp_ channel,
// one transfer per result, last on the final one; a mark count mismatch gives a
// single error transfer instead. The result register parts the two sides: while
// rsp_ready is low the current transfer holds and the block waits before loading
// the next one. After reset the distance store is swept to zero with req_ready
// low; configuration writes through the APB port are taken at any time.
`default_nettype none

module min_diff_dispersion_swap_descent
   import mddsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic [5:0]        req_first_index,
   input  wire logic [5:0]        req_second_index,
   input  wire logic [15:0]       req_distance,
   input  wire logic              req_member_flag,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [5:0]             rsp_chosen_element,
   output logic [20:0]            rsp_solution_cost,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam logic [1:0] REG_ELEMENT_COUNT = 2'd0;
   localparam logic [1:0] REG_CHOSEN_COUNT  = 2'd1;
   localparam logic [1:0] REG_MAX_PASSES    = 2'd2;

   logic [6:0]  element_count_ff;
   logic [5:0]  chosen_count_ff;
   logic [15:0] max_passes_ff;
   logic        cfg_write;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   // write the register selected by the word address at the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= 7'd64;
         chosen_count_ff  <= 6'd8;
         max_passes_ff    <= 16'hFFFF;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_ELEMENT_COUNT: element_count_ff <= pwdata[6:0];
            REG_CHOSEN_COUNT:  chosen_count_ff  <= pwdata[5:0];
            REG_MAX_PASSES:    max_passes_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ELEMENT_COUNT: prdata = {25'd0, element_count_ff};
         REG_CHOSEN_COUNT:  prdata = {26'd0, chosen_count_ff};
         REG_MAX_PASSES:    prdata = {16'd0, max_passes_ff};
         default:           prdata = '0;
      endcase
   end

   // sequence every run step; loop counters live here
   mddsd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .element_count (element_count_ff),
      .chosen_count  (chosen_count_ff),
      .max_passes    (max_passes_ff),
      .stat          (stat),
      .cmd           (cmd)
   );

   // stores, swap arithmetic and the result register
   mddsd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_first_index    (req_first_index),
      .req_second_index   (req_second_index),
      .req_distance       (req_distance),
      .req_member_flag    (req_member_flag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chosen_element (rsp_chosen_element),
      .rsp_solution_cost  (rsp_solution_cost),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   // the clearing sweep blocks items right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item taken during the clearing sweep");

   // a mismatch transfer is the single, empty final result of its run
   a_mismatch_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MISMATCH |->
         rsp_last && rsp_chosen_element == 6'd0 && rsp_solution_cost == 21'd0)
      else $error("malformed mismatch result");

endmodule

`default_nettype wire
